// ===== design/skvt_pkg.sv =====
// Shared types and constants for the sorted key-value table.
// Used by the cell, the top level and the port checker.
package skvt_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValW   = 32;
  localparam int unsigned OpW    = 2;
  localparam int unsigned CountW = 7;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic            cmp_en;
    logic            upd_en;
    logic            do_ins;
    logic            do_upd;
    logic            do_rem;
    logic            descending;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } cell_cmd_t;

endpackage

// ===== design/skvt_cell.sv =====
// One slot of the sorted key-value table: a stored pair, its compare flags
// and the shift logic toward both neighbors. Depends on skvt_pkg.
module skvt_cell import skvt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_cmd_t       cmd_i,
  input  logic            valid_i,
  input  logic [KeyW-1:0] left_key_i,
  input  logic [ValW-1:0] left_val_i,
  input  logic [KeyW-1:0] right_key_i,
  input  logic [ValW-1:0] right_val_i,
  input  logic            ins_chain_i,
  input  logic            rem_chain_i,
  input  logic [ValW-1:0] val_chain_i,
  output logic [KeyW-1:0] key_o,
  output logic [ValW-1:0] val_o,
  output logic            ins_chain_o,
  output logic            rem_chain_o,
  output logic [ValW-1:0] val_chain_o
);

  logic [KeyW-1:0] key_q, key_d;
  logic [ValW-1:0] val_q, val_d;
  logic            match_q, match_d;
  logic            prec_q, prec_d;
  logic            new_first;

  // An empty slot counts as preceded, so the first empty slot takes a new key
  // when no stored key follows it.
  always_comb begin
    match_d = match_q;
    prec_d  = prec_q;
    if (cmd_i.cmp_en) begin
      match_d = valid_i && (key_q == cmd_i.key);
      if (!valid_i) begin
        prec_d = 1'b1;
      end else if (cmd_i.descending) begin
        prec_d = $signed(cmd_i.key) > $signed(key_q);
      end else begin
        prec_d = $signed(cmd_i.key) < $signed(key_q);
      end
    end
  end

  assign new_first = prec_q && !ins_chain_i;

  always_comb begin
    key_d = key_q;
    val_d = val_q;
    if (cmd_i.upd_en) begin
      if (cmd_i.do_ins) begin
        if (ins_chain_i) begin
          key_d = left_key_i;
          val_d = left_val_i;
        end else if (new_first) begin
          key_d = cmd_i.key;
          val_d = cmd_i.value;
        end
      end
      if (cmd_i.do_upd && match_q) begin
        val_d = cmd_i.value;
      end
      if (cmd_i.do_rem && (rem_chain_i || match_q)) begin
        key_d = right_key_i;
        val_d = right_val_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      prec_q  <= 1'b0;
    end else begin
      match_q <= match_d;
      prec_q  <= prec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

  assign key_o       = key_q;
  assign val_o       = val_q;
  assign ins_chain_o = ins_chain_i || prec_q;
  assign rem_chain_o = rem_chain_i || match_q;
  assign val_chain_o = val_chain_i | (match_q ? val_q : '0);

endmodule

// ===== design/sorted_key_value_table.sv =====
// Each operation passes through the compare pass and then the shift pass of the chain
// of cells before its result beat is registered; a new input beat is accepted only
// once the previous operation is through; a result stalled at the output holds
// the shift pass until it is taken.
// Reset empties the table and selects ascending key order.
// Top level of the sorted key-value table. Depends on skvt_pkg, skvt_cell.
module sorted_key_value_table import skvt_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,   // order_descending
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // key[31:0], value[63:32]
  input  logic [OpW-1:0]      s_axis_tuser,  // op[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // hit[0], value_out[32:1],
                                             // full_res[33], entry_count[40:34]
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e state_q, state_d;
  logic   desc_q;
  logic [CW-1:0] count_q, count_d;
  logic [OpW-1:0]  op_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;
  logic m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;

  logic in_fire, upd_fire, upd_stall;
  logic hit, full, op_known;
  cell_cmd_t cmd;

  logic [KeyW-1:0] cell_key [CAPACITY];
  logic [ValW-1:0] cell_val [CAPACITY];
  logic            ins_chain [CAPACITY+1];
  logic            rem_chain [CAPACITY+1];
  logic [ValW-1:0] val_chain [CAPACITY+1];

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign upd_stall = m_valid_q && !m_axis_tready;
  assign upd_fire  = (state_q == ST_UPD) && !upd_stall;

  assign op_known = (op_q == OP_ADD) || (op_q == OP_SEARCH) || (op_q == OP_REMOVE);
  assign hit      = op_known && rem_chain[CAPACITY];
  assign full     = (count_q == CW'(CAPACITY));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_CMP;
      ST_CMP:  state_d = ST_UPD;
      ST_UPD:  if (!upd_stall) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_axis_tready  = 1'b0;
    cmd            = '0;
    cmd.descending = desc_q;
    cmd.key        = key_q;
    cmd.value      = val_q;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_CMP:  cmd.cmp_en = 1'b1;
      ST_UPD:  begin
        cmd.upd_en = upd_fire;
        cmd.do_ins = (op_q == OP_ADD) && !hit && !full;
        cmd.do_upd = (op_q == OP_ADD) && hit;
        cmd.do_rem = (op_q == OP_REMOVE) && hit;
      end
      default: s_axis_tready = 1'b0;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (upd_fire && cmd.do_ins) begin
      count_d = count_q + CW'(1);
    end else if (upd_fire && cmd.do_rem) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (upd_fire) begin
      m_valid_d = 1'b1;
      m_data_d  = {7'b0, CountW'(count_d),
                   (op_q == OP_ADD) && !hit && full,
                   hit ? val_chain[CAPACITY] : {ValW{1'b0}},
                   hit};
    end
  end

  assign ins_chain[0] = 1'b0;
  assign rem_chain[0] = 1'b0;
  assign val_chain[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic            valid;
    logic [KeyW-1:0] left_key, right_key;
    logic [ValW-1:0] left_val, right_val;

    assign valid = (CW'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_key = key_q;
      assign left_val = val_q;
    end else begin : g_mid
      assign left_key = cell_key[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[i];
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
      assign right_val = cell_val[i+1];
    end

    skvt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .valid_i     (valid),
      .left_key_i  (left_key),
      .left_val_i  (left_val),
      .right_key_i (right_key),
      .right_val_i (right_val),
      .ins_chain_i (ins_chain[i]),
      .rem_chain_i (rem_chain[i]),
      .val_chain_i (val_chain[i]),
      .key_o       (cell_key[i]),
      .val_o       (cell_val[i]),
      .ins_chain_o (ins_chain[i+1]),
      .rem_chain_o (rem_chain[i+1]),
      .val_chain_o (val_chain[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      desc_q    <= 1'b0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        desc_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    if (in_fire) begin
      op_q  <= s_axis_tuser;
      key_q <= s_axis_tdata[KeyW-1:0];
      val_q <= s_axis_tdata[KeyW+ValW-1:KeyW];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== design/skvt_checker.sv =====
// Port-level checks for the sorted key-value table, bound to the top level.
// Depends on skvt_pkg.
module skvt_checker import skvt_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic [CountW-1:0] cnt;
  assign cnt = m_axis_tdata[40:34];

  // A refused add never reports a stored key.
  a_hit_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[33]))
    else $error("hit and full_res both set");

  // A miss carries a zero value.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[32:1] == '0))
    else $error("value_out nonzero without hit");

  // A refused add leaves the table at capacity.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[33]) |-> (cnt == CountW'(CAPACITY)))
    else $error("full_res with table not full");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result beat changed while stalled");

endmodule

bind sorted_key_value_table skvt_checker #(.CAPACITY(CAPACITY)) u_skvt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
